>>> rtl/core/mckr_pkg.sv
package mckr_pkg;

    // Table sizes
    localparam int COMBO_ENTRIES = 16;
    localparam int MOD_ENTRIES   = 8;
    localparam int KEY_CODES     = 1024;

    localparam int CIDX_W = (COMBO_ENTRIES > 1) ? $clog2(COMBO_ENTRIES) : 1;
    localparam int MIDX_W = (MOD_ENTRIES > 1) ? $clog2(MOD_ENTRIES) : 1;
    localparam int KEY_W  = $clog2(KEY_CODES);

    // Field widths fixed by the stream format
    localparam int CODE_W      = 10;
    localparam int STATE_W     = 2;
    localparam int IDX_W       = 4;
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;

    // Short queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    localparam logic [STATE_W-1:0] ST_REL    = 2'd0;
    localparam logic [STATE_W-1:0] ST_PRESS  = 2'd1;
    localparam logic [STATE_W-1:0] ST_REPEAT = 2'd2;

    typedef enum logic [1:0] {
        CMD_KEY      = 2'd0,
        CMD_COMBO_WR = 2'd1,
        CMD_MOD_WR   = 2'd2,
        CMD_FLAG_WR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_KEY      = 3'd1,
        OP_COMBO_WR = 3'd2,
        OP_MOD_WR   = 3'd3,
        OP_FLAG_WR  = 3'd4
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               key_ok;
        logic [CODE_W-1:0]  key_code;
        logic [STATE_W-1:0] key_state;
        logic [IDX_W-1:0]   entry_index;
        logic [CODE_W-1:0]  from_mod;
        logic [CODE_W-1:0]  from_key;
        logic [CODE_W-1:0]  to_mod;
        logic [CODE_W-1:0]  to_key;
        logic               entry_valid;
        logic               modifier_flag;
    } t_item;

    typedef struct packed {
        logic pop;
        logic clr_busy;
    } t_back_ctl;

endpackage

>>> rtl/core/mckr_front.sv
module mckr_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [mckr_pkg::IN_TDATA_W-1:0]  i_data,
    input  logic [mckr_pkg::IN_TUSER_W-1:0]  i_user,
    input  mckr_pkg::t_back_ctl              i_ctl,
    output logic                             o_q_valid,
    output mckr_pkg::t_item                  o_item
);
    import mckr_pkg::*;

    t_item             cls_item;
    t_cmd              cmd;
    logic              push;
    logic              pop;
    t_item             r_q [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_cnt;
    logic [Q_AW-1:0]   n_wr_ptr;
    logic [Q_AW-1:0]   n_rd_ptr;
    logic [Q_AW:0]     n_cnt;

    // Classify: unpack the fields and turn out-of-range writes into no-ops
    always_comb begin
        cmd                    = t_cmd'(i_user);
        cls_item.key_code      = i_data[9:0];
        cls_item.key_state     = i_data[11:10];
        cls_item.entry_index   = i_data[15:12];
        cls_item.from_mod      = i_data[25:16];
        cls_item.from_key      = i_data[35:26];
        cls_item.to_mod        = i_data[45:36];
        cls_item.to_key        = i_data[55:46];
        cls_item.entry_valid   = i_data[56];
        cls_item.modifier_flag = i_data[57];
        cls_item.key_ok        = 32'(i_data[9:0]) < KEY_CODES;
        case (cmd)
            CMD_KEY: begin
                cls_item.op = OP_KEY;
            end
            CMD_COMBO_WR: begin
                cls_item.op = (32'(i_data[15:12]) < COMBO_ENTRIES) ? OP_COMBO_WR : OP_NOP;
            end
            CMD_MOD_WR: begin
                cls_item.op = (32'(i_data[15:12]) < MOD_ENTRIES) ? OP_MOD_WR : OP_NOP;
            end
            CMD_FLAG_WR: begin
                cls_item.op = cls_item.key_ok ? OP_FLAG_WR : OP_NOP;
            end
            default: begin
                cls_item.op = OP_NOP;
            end
        endcase
    end

    assign o_ready   = !i_ctl.clr_busy && (r_cnt != (Q_AW + 1)'(Q_DEPTH));
    assign push      = i_valid && o_ready;
    assign pop       = i_ctl.pop;
    assign o_q_valid = (r_cnt != '0);
    assign o_item    = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls_item;
        end
    end

endmodule

>>> rtl/core/mckr_back.sv
module mckr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  mckr_pkg::t_item               i_item,
    output mckr_pkg::t_back_ctl           o_ctl,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mckr_pkg::CODE_W-1:0]   o_out_code,
    output logic [mckr_pkg::STATE_W-1:0]  o_out_state,
    output logic                          o_out_last
);
    import mckr_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_SCAN_C = 6'b001000,
        S_SCAN_M = 6'b010000,
        S_EMIT   = 6'b100000
    } t_seq;

    typedef enum logic [4:0] {
        M_WAIT_MOD   = 5'b00001,
        M_WAIT_COMBO = 5'b00010,
        M_IN_COMBO   = 5'b00100,
        M_CLEAN      = 5'b01000,
        M_RECOMBO    = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [1:0]         cnt;
        logic [CODE_W-1:0]  c0;
        logic [STATE_W-1:0] s0;
        logic [CODE_W-1:0]  c1;
        logic [STATE_W-1:0] s1;
    } t_evs;

    function automatic t_evs f_one(input logic [CODE_W-1:0] c, input logic [STATE_W-1:0] s);
        t_evs e;
        e     = '0;
        e.cnt = 2'd1;
        e.c0  = c;
        e.s0  = s;
        return e;
    endfunction

    function automatic t_evs f_two(input logic [CODE_W-1:0] ca, input logic [CODE_W-1:0] cb,
                                   input logic [STATE_W-1:0] s);
        t_evs e;
        e.cnt = 2'd2;
        e.c0  = ca;
        e.s0  = s;
        e.c1  = cb;
        e.s1  = s;
        return e;
    endfunction

    // Events for sending the active chord in state s
    function automatic t_evs f_chord(input logic [CODE_W-1:0] amod, input logic [CODE_W-1:0] akey,
                                     input logic [STATE_W-1:0] s);
        t_evs e;
        e = '0;
        if (amod == '0) begin
            e = f_one(akey, s);
        end else begin
            case (s)
                ST_PRESS:  e = f_two(amod, akey, s);
                ST_REPEAT: e = f_one(akey, s);
                ST_REL:    e = f_two(akey, amod, s);
                default:   e = '0;
            endcase
        end
        return e;
    endfunction

    t_seq               r_seq, n_seq;
    t_mode              r_mode, n_mode;
    logic [CODE_W-1:0]  r_held_mod, n_held_mod;
    logic [CODE_W-1:0]  r_held_key, n_held_key;
    logic [CODE_W-1:0]  r_active_mod, n_active_mod;
    logic [CODE_W-1:0]  r_active_key, n_active_key;
    t_item              r_cur, n_cur;
    logic [KEY_W-1:0]   r_clr_addr, n_clr_addr;
    logic [CIDX_W-1:0]  r_scan_c, n_scan_c;
    logic [MIDX_W-1:0]  r_scan_m, n_scan_m;
    t_evs               r_evs, n_evs;
    logic               r_ev_sel, n_ev_sel;
    logic               r_out_valid, n_out_valid;
    logic [CODE_W-1:0]  r_out_code, n_out_code;
    logic [STATE_W-1:0] r_out_state, n_out_state;
    logic               r_out_last, n_out_last;

    logic               r_c_valid [COMBO_ENTRIES];
    logic [CODE_W-1:0]  r_c_fmod  [COMBO_ENTRIES];
    logic [CODE_W-1:0]  r_c_fkey  [COMBO_ENTRIES];
    logic [CODE_W-1:0]  r_c_tmod  [COMBO_ENTRIES];
    logic [CODE_W-1:0]  r_c_tkey  [COMBO_ENTRIES];
    logic               r_m_valid [MOD_ENTRIES];
    logic [CODE_W-1:0]  r_m_fmod  [MOD_ENTRIES];
    logic [CODE_W-1:0]  r_m_tmod  [MOD_ENTRIES];

    logic               r_flags [KEY_CODES];
    logic               r_flag;

    logic               pop;
    logic               c_we, m_we;
    logic [CIDX_W-1:0]  c_widx;
    logic [MIDX_W-1:0]  m_widx;
    logic               mem_we;
    logic               mem_wd;
    logic [KEY_W-1:0]   mem_addr;
    logic               c_match, c_dis, c_last;
    logic               m_match, m_last;
    logic               fin;
    t_evs               evs;
    logic               out_free;

    assign pop    = (r_seq == S_IDLE) && i_q_valid;
    assign c_we   = pop && (i_item.op == OP_COMBO_WR);
    assign m_we   = pop && (i_item.op == OP_MOD_WR);
    assign c_widx = CIDX_W'(i_item.entry_index);
    assign m_widx = MIDX_W'(i_item.entry_index);

    assign o_ctl.pop      = pop;
    assign o_ctl.clr_busy = (r_seq == S_CLEAR);

    // Flag memory: the clearing pass and flag writes share the one port with key reads
    assign mem_we   = (r_seq == S_CLEAR) || (pop && (i_item.op == OP_FLAG_WR));
    assign mem_wd   = (r_seq == S_CLEAR) ? 1'b0 : i_item.modifier_flag;
    assign mem_addr = (r_seq == S_CLEAR) ? r_clr_addr : KEY_W'(i_item.key_code);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_flags[mem_addr] <= mem_wd;
        end
        r_flag <= r_flags[mem_addr];
    end

    assign c_match = r_c_valid[r_scan_c] && (r_c_fmod[r_scan_c] == r_held_mod)
                     && (r_c_fkey[r_scan_c] == r_cur.key_code);
    assign c_dis   = (r_c_tmod[r_scan_c] == '0) && (r_c_tkey[r_scan_c] == '0);
    assign c_last  = (r_scan_c == CIDX_W'(COMBO_ENTRIES - 1));
    assign m_match = r_m_valid[r_scan_m] && (r_m_fmod[r_scan_m] == r_held_mod);
    assign m_last  = (r_scan_m == MIDX_W'(MOD_ENTRIES - 1));
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_seq        = r_seq;
        n_mode       = r_mode;
        n_held_mod   = r_held_mod;
        n_held_key   = r_held_key;
        n_active_mod = r_active_mod;
        n_active_key = r_active_key;
        n_cur        = r_cur;
        n_clr_addr   = r_clr_addr;
        n_scan_c     = r_scan_c;
        n_scan_m     = r_scan_m;
        n_evs        = r_evs;
        n_ev_sel     = r_ev_sel;
        n_out_valid  = r_out_valid;
        n_out_code   = r_out_code;
        n_out_state  = r_out_state;
        n_out_last   = r_out_last;
        fin          = 1'b0;
        evs          = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_seq)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == KEY_W'(KEY_CODES - 1)) begin
                    n_seq = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_cur = i_item;
                    if (i_item.op == OP_KEY) begin
                        n_seq = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                fin = 1'b1;
                case (r_mode)
                    M_WAIT_COMBO: begin
                        if (r_cur.key_state == ST_PRESS) begin
                            fin      = 1'b0;
                            n_scan_c = '0;
                            n_seq    = S_SCAN_C;
                        end else begin
                            evs    = f_two(r_held_mod, r_cur.key_code, ST_PRESS);
                            evs.s1 = r_cur.key_state;
                            n_mode = M_WAIT_MOD;
                        end
                    end
                    M_IN_COMBO: begin
                        if (r_cur.key_code == r_held_mod || r_cur.key_code == r_held_key) begin
                            evs = f_chord(r_active_mod, r_active_key, r_cur.key_state);
                            if (r_cur.key_state == ST_REL) begin
                                n_mode = (r_cur.key_code == r_held_mod) ? M_CLEAN : M_RECOMBO;
                            end
                        end else begin
                            evs = f_one(r_cur.key_code, r_cur.key_state);
                        end
                    end
                    M_CLEAN: begin
                        if (r_cur.key_code == r_held_key) begin
                            if (r_cur.key_state == ST_REL) begin
                                n_mode = M_WAIT_MOD;
                            end
                        end else begin
                            evs = f_one(r_cur.key_code, r_cur.key_state);
                        end
                    end
                    M_RECOMBO: begin
                        if (r_cur.key_code == r_held_mod) begin
                            if (r_cur.key_state == ST_REL) begin
                                n_mode = M_WAIT_MOD;
                            end
                        end else if (r_cur.key_state == ST_PRESS) begin
                            fin      = 1'b0;
                            n_scan_c = '0;
                            n_seq    = S_SCAN_C;
                        end else begin
                            evs = f_one(r_cur.key_code, r_cur.key_state);
                        end
                    end
                    default: begin
                        n_mode = M_WAIT_MOD;
                        if (r_cur.key_ok && r_flag && r_cur.key_state == ST_PRESS) begin
                            n_held_mod = r_cur.key_code;
                            n_mode     = M_WAIT_COMBO;
                        end else begin
                            evs = f_one(r_cur.key_code, r_cur.key_state);
                        end
                    end
                endcase
            end
            S_SCAN_C: begin
                if (c_match && !c_dis) begin
                    fin          = 1'b1;
                    n_active_mod = r_c_tmod[r_scan_c];
                    n_active_key = r_c_tkey[r_scan_c];
                    n_held_key   = r_cur.key_code;
                    n_mode       = M_IN_COMBO;
                    evs = f_chord(r_c_tmod[r_scan_c], r_c_tkey[r_scan_c], ST_PRESS);
                end else if (c_match || (c_last && 1'b0)) begin
                    // disabled chord: no remap
                    fin = 1'b1;
                    if (r_mode == M_WAIT_COMBO) begin
                        evs    = f_two(r_held_mod, r_cur.key_code, ST_PRESS);
                        evs.s1 = r_cur.key_state;
                        n_mode = M_WAIT_MOD;
                    end else begin
                        evs = f_one(r_cur.key_code, r_cur.key_state);
                    end
                end else if (c_last) begin
                    n_scan_m = '0;
                    n_seq    = S_SCAN_M;
                end else begin
                    n_scan_c = r_scan_c + 1'b1;
                end
            end
            S_SCAN_M: begin
                if (m_match) begin
                    fin          = 1'b1;
                    n_active_mod = r_m_tmod[r_scan_m];
                    n_active_key = r_cur.key_code;
                    n_held_key   = r_cur.key_code;
                    n_mode       = M_IN_COMBO;
                    evs = f_chord(r_m_tmod[r_scan_m], r_cur.key_code, ST_PRESS);
                end else if (m_last) begin
                    fin = 1'b1;
                    if (r_mode == M_WAIT_COMBO) begin
                        evs    = f_two(r_held_mod, r_cur.key_code, ST_PRESS);
                        evs.s1 = r_cur.key_state;
                        n_mode = M_WAIT_MOD;
                    end else begin
                        evs = f_one(r_cur.key_code, r_cur.key_state);
                    end
                end else begin
                    n_scan_m = r_scan_m + 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = r_ev_sel ? r_evs.c1 : r_evs.c0;
                    n_out_state = r_ev_sel ? r_evs.s1 : r_evs.s0;
                    n_out_last  = r_ev_sel || (r_evs.cnt == 2'd1);
                    if (r_ev_sel || (r_evs.cnt == 2'd1)) begin
                        n_ev_sel = 1'b0;
                        n_seq    = S_IDLE;
                    end else begin
                        n_ev_sel = 1'b1;
                    end
                end
            end
            default: begin
                n_seq = S_IDLE;
            end
        endcase

        if (fin) begin
            n_evs    = evs;
            n_ev_sel = 1'b0;
            n_seq    = (evs.cnt != 2'd0) ? S_EMIT : S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= S_CLEAR;
            r_mode       <= M_WAIT_MOD;
            r_held_mod   <= '0;
            r_held_key   <= '0;
            r_active_mod <= '0;
            r_active_key <= '0;
            r_clr_addr   <= '0;
            r_ev_sel     <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < COMBO_ENTRIES; i++) begin
                r_c_valid[i] <= 1'b0;
            end
            for (int i = 0; i < MOD_ENTRIES; i++) begin
                r_m_valid[i] <= 1'b0;
            end
        end else begin
            r_seq        <= n_seq;
            r_mode       <= n_mode;
            r_held_mod   <= n_held_mod;
            r_held_key   <= n_held_key;
            r_active_mod <= n_active_mod;
            r_active_key <= n_active_key;
            r_clr_addr   <= n_clr_addr;
            r_ev_sel     <= n_ev_sel;
            r_out_valid  <= n_out_valid;
            if (c_we) begin
                r_c_valid[c_widx] <= i_item.entry_valid;
            end
            if (m_we) begin
                r_m_valid[m_widx] <= i_item.entry_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_scan_c    <= n_scan_c;
        r_scan_m    <= n_scan_m;
        r_evs       <= n_evs;
        r_out_code  <= n_out_code;
        r_out_state <= n_out_state;
        r_out_last  <= n_out_last;
        if (c_we) begin
            r_c_fmod[c_widx] <= i_item.from_mod;
            r_c_fkey[c_widx] <= i_item.from_key;
            r_c_tmod[c_widx] <= i_item.to_mod;
            r_c_tkey[c_widx] <= i_item.to_key;
        end
        if (m_we) begin
            r_m_fmod[m_widx] <= i_item.from_mod;
            r_m_tmod[m_widx] <= i_item.to_mod;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_code  = r_out_code;
    assign o_out_state = r_out_state;
    assign o_out_last  = r_out_last;

endmodule

>>> rtl/core/modifier_combo_key_remapper_unit.sv
// Modifier combo key remapper. Takes key events and table/flag load commands on the slave
// stream (tuser = command) and sends remapped key events on the master stream, with tlast on
// the last event caused by an input. After reset the block sweeps its modifier flag memory,
// one entry per cycle, through all KEY_CODES (1024) entries with tready low. A transfer enters
// a two-entry queue; the back end then takes a load command straight from idle, while a key
// event passes a decide step, a chord lookup if needed that scans the combo and modifier tables
// one entry a cycle (up to COMBO_ENTRIES + MOD_ENTRIES, 16 + 8 entries), and an emit step for
// each event. The output register lets the next item proceed while a result waits to be taken.
module modifier_combo_key_remapper_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // key_code[9:0], key_state[11:10], entry_index[15:12], from_mod[25:16],
    // from_key[35:26], to_mod[45:36], to_key[55:46], entry_valid[56], modifier_flag[57]
    input  logic [mckr_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    // command[1:0]
    input  logic [mckr_pkg::IN_TUSER_W-1:0]       i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // out_code[9:0], out_state[11:10]
    output logic [mckr_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                                  o_m_axis_tlast
);
    import mckr_pkg::*;

    logic               q_valid;
    t_item              q_item;
    t_back_ctl          back_ctl;
    logic [CODE_W-1:0]  out_code;
    logic [STATE_W-1:0] out_state;

    mckr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_user    (i_s_axis_tuser),
        .i_ctl     (back_ctl),
        .o_q_valid (q_valid),
        .o_item    (q_item)
    );

    mckr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_item      (q_item),
        .o_ctl       (back_ctl),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_code  (out_code),
        .o_out_state (out_state),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {(OUT_TDATA_W - CODE_W - STATE_W)'(0), out_state, out_code};

endmodule

>>> rtl/core/mckr_checker.sv
module mckr_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_s_axis_tready,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [mckr_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                              o_m_axis_tlast
);
    import mckr_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // Reset drops any pending result
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // The flag memory sweep follows reset, so no transfer is taken right after it
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready during clearing pass");

    // Padding bits above out_state stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[OUT_TDATA_W-1:CODE_W+STATE_W] == '0))
        else $error("nonzero padding in result");

endmodule

bind modifier_combo_key_remapper_unit mckr_checker u_mckr_checker (.*);
